### src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/sdla_pkg.sv
// Package for the segment direction and lock arbiter.
// Holds opcodes, status codes and parameter defaults; no dependencies.
package sdla_pkg;

    localparam int SDLA_MAX_AGENTS    = 8;
    localparam int SDLA_AGENT_ID_BITS = 8;

    localparam logic [2:0] OP_APPLY     = 3'd0;
    localparam logic [2:0] OP_RELEASE   = 3'd1;
    localparam logic [2:0] OP_RESET_DIR = 3'd2;
    localparam logic [2:0] OP_SET_DIR   = 3'd3;
    localparam logic [2:0] OP_TAKE_LOCK = 3'd4;
    localparam logic [2:0] OP_DROP_LOCK = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic signed [1:0] DIR_FREE = 2'sb11;

endpackage

### src/segment_direction_lock_arbiter_unit.sv
// Done pulses after the slot scan (S_SCAN) and the execute state (S_EXEC);
// busy stays high meanwhile, so a new command waits for the last one. The
// slot scan reads one occupant entry per cycle through a single comparator.
// Results cannot be stalled; done is high for exactly one cycle per command.
// Reset (rst_n low, asynchronous) frees the direction, clears the lock, empties
// the occupant set, selects double-entry mode and returns the sequencer to idle.
//
// Top level of the segment direction and lock arbiter; uses sdla_pkg.
module segment_direction_lock_arbiter_unit #(
    parameter int MAX_AGENTS    = sdla_pkg::SDLA_MAX_AGENTS,
    parameter int AGENT_ID_BITS = sdla_pkg::SDLA_AGENT_ID_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    // Configuration: single-entry mode bit.
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    // Command channel.
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        opcode,
    input  logic [7:0]        agent_id,
    input  logic              requested_direction,
    // Result channel.
    output logic              done,
    output logic [1:0]        status,
    output logic signed [1:0] direction_now,
    output logic              locked,
    output logic [3:0]        occupant_count
);
    import sdla_pkg::*;

    localparam int IDX_W = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CNT_W = $clog2(MAX_AGENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_AGENTS);

    // Sequencer codes.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    // The occupant IDs live in a small memory. The valid bits are flip-flops
    // so that reset empties the set at once.
    logic [AGENT_ID_BITS-1:0] occ_mem [MAX_AGENTS];
    logic [AGENT_ID_BITS-1:0] rdata_reg;
    logic [MAX_AGENTS-1:0]    valid_reg, valid_next;

    logic [1:0]               state_reg, state_next;
    logic                     mode_reg;
    logic                     dir_free_reg, dir_free_next;
    logic                     dir_val_reg, dir_val_next;
    logic                     lock_reg, lock_next;

    // Latched command.
    logic [2:0]               op_reg, op_next;
    logic [AGENT_ID_BITS-1:0] id_reg, id_next;
    logic                     req_reg, req_next;

    // Scan state: the counter issues reads, the compare stage sees the entry
    // read in the previous cycle.
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic [CNT_W-1:0]         occ_cnt_reg, occ_cnt_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_reg, free_next;

    // Result registers.
    logic                     done_reg, done_next;
    logic [1:0]               status_reg, status_next;
    logic [CNT_W-1:0]         out_cnt_reg, out_cnt_next;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [AGENT_ID_BITS+7:0] id_wide;
    logic                     cmp_valid;
    logic                     cmp_hit;
    logic                     sole;
    logic                     grant;
    logic [CNT_W+3:0]         cnt_wide;

    // Only the low AGENT_ID_BITS bits of the agent ID take part.
    assign id_wide = {{AGENT_ID_BITS{1'b0}}, agent_id};

    assign rd_addr   = (cnt_reg == CNT_MAX) ? '0 : cnt_reg[IDX_W-1:0];
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign cmp_hit   = cmp_valid && (rdata_reg == id_reg);
    assign sole      = (occ_cnt_reg == CNT_W'(1)) && found_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        occ_cnt_next    = occ_cnt_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        valid_next      = valid_reg;
        dir_free_next   = dir_free_reg;
        dir_val_next    = dir_val_reg;
        lock_next       = lock_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        out_cnt_next    = out_cnt_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        grant           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = opcode;
                    id_next         = id_wide[AGENT_ID_BITS-1:0];
                    req_next        = requested_direction;
                    cnt_next        = '0;
                    occ_cnt_next    = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // The entry read in the previous cycle is checked once the
                // counter has moved past the first address.
                if (cnt_reg != '0)
                begin
                    occ_cnt_next = occ_cnt_reg + CNT_W'(cmp_valid);
                    if (cmp_hit && !found_reg)
                    begin
                        found_next = 1'b1;
                        pos_next   = cmp_idx_reg;
                    end
                    if (!cmp_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_next       = cmp_idx_reg;
                    end
                end
                if (cnt_reg == CNT_MAX)
                    state_next = S_EXEC;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end

            S_EXEC:
            begin
                status_next  = ST_REFUSED;
                out_cnt_next = occ_cnt_reg;
                case (op_reg)
                    OP_APPLY:
                    begin
                        if (mode_reg)
                            grant = !lock_reg && ((occ_cnt_reg == '0) || sole);
                        else
                            grant = dir_free_reg
                                 || (!dir_free_reg && (dir_val_reg == req_reg) && !lock_reg)
                                 || (!lock_reg && sole);
                        if (grant)
                        begin
                            if (!found_reg && !free_found_reg)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = found_reg ? pos_reg : free_reg;
                                valid_next[mem_waddr] = 1'b1;
                                dir_free_next = 1'b0;
                                dir_val_next  = req_reg;
                                if (mode_reg)
                                    lock_next = 1'b1;
                                if (!found_reg)
                                    out_cnt_next = occ_cnt_reg + CNT_W'(1);
                                status_next   = ST_OK;
                            end
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (found_reg)
                        begin
                            valid_next[pos_reg] = 1'b0;
                            out_cnt_next        = occ_cnt_reg - CNT_W'(1);
                            status_next         = ST_OK;
                        end
                    end
                    OP_RESET_DIR:
                    begin
                        if (occ_cnt_reg == '0)
                        begin
                            dir_free_next = 1'b1;
                            status_next   = ST_OK;
                        end
                    end
                    OP_SET_DIR:
                    begin
                        if (dir_free_reg || (sole && (dir_val_reg != req_reg)))
                        begin
                            dir_free_next = 1'b0;
                            dir_val_next  = req_reg;
                            status_next   = ST_OK;
                        end
                    end
                    OP_TAKE_LOCK:
                    begin
                        if (!lock_reg)
                        begin
                            lock_next   = 1'b1;
                            status_next = ST_OK;
                        end
                    end
                    OP_DROP_LOCK:
                    begin
                        if (lock_reg)
                        begin
                            lock_next   = 1'b0;
                            status_next = ST_OK;
                        end
                    end
                    default:
                    begin
                        status_next = ST_REFUSED;
                    end
                endcase
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= 1'b0;
            valid_reg    <= '0;
            dir_free_reg <= 1'b1;
            dir_val_reg  <= 1'b0;
            lock_reg     <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            out_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
                mode_reg <= cfg_wdata;
            valid_reg    <= valid_next;
            dir_free_reg <= dir_free_next;
            dir_val_reg  <= dir_val_next;
            lock_reg     <= lock_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    // Command and scan payload; no reset needed.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        req_reg        <= req_next;
        cnt_reg        <= cnt_next;
        cmp_idx_reg    <= rd_addr;
        occ_cnt_reg    <= occ_cnt_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
    end

    // Occupant ID memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            occ_mem[mem_waddr] <= id_reg;
        rdata_reg <= occ_mem[rd_addr];
    end

    assign cnt_wide       = {4'b0000, out_cnt_reg};
    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign direction_now  = dir_free_reg ? DIR_FREE : $signed({1'b0, dir_val_reg});
    assign locked         = lock_reg;
    assign occupant_count = cnt_wide[3:0];

endmodule

### src/sdla_checker.sv
// Port-level checker for the segment direction and lock arbiter.
// Uses sdla_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module sdla_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [1:0]        status,
    input logic signed [1:0] direction_now,
    input logic [3:0]        occupant_count
);
    import sdla_pkg::*;

    // An accepted command always occupies the block in the next cycle.
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // A result never follows another in the next cycle.
    `ASSERT_NEXT(a_done_single, done, !done)
    // Status is always one of the defined codes.
    `ASSERT_SAME(a_status_code, done, status == ST_OK || status == ST_REFUSED || status == ST_FULL)
    // Direction and occupancy only move together with a result.
    `ASSERT_SAME(a_state_quiet, !done, $stable(occupant_count) && $stable(direction_now))
    // The direction is never the unused code.
    `ASSERT_SAME(a_dir_code, 1'b1, direction_now != 2'sb10)

endmodule

bind segment_direction_lock_arbiter_unit sdla_checker u_sdla_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the segment direction and lock arbiter unit.
// Depends on sdla_pkg and segment_direction_lock_arbiter_unit; predicts each reply in a class.

typedef struct {
    logic [1:0] status;
    logic [1:0] direction;
    logic       locked;
    logic [3:0] occupants;
} arbiter_reply_t;

class segment_arbiter_scoreboard;
    // Predicted segment state, kept at the widths of the block.
    logic [1:0] seg_dir;
    logic       seg_lock;
    logic [7:0] slot_id [sdla_pkg::SDLA_MAX_AGENTS];
    logic       slot_used [sdla_pkg::SDLA_MAX_AGENTS];
    logic       single_entry;

    arbiter_reply_t awaited_replies[$];
    int mismatches;
    int commands;
    int grants;
    int full_replies;
    int refusals;

    function new();
        seg_dir = sdla_pkg::DIR_FREE;
        seg_lock = 1'b0;
        single_entry = 1'b0;
        for (int i = 0; i < sdla_pkg::SDLA_MAX_AGENTS; i++)
        begin
            slot_id[i] = '0;
            slot_used[i] = 1'b0;
        end
        mismatches = 0;
        commands = 0;
        grants = 0;
        full_replies = 0;
        refusals = 0;
    endfunction

    function void set_mode(logic mode);
        single_entry = mode;
    endfunction

    function int outstanding();
        return awaited_replies.size();
    endfunction

    function int occupant_total();
        int n;
        n = 0;
        for (int i = 0; i < sdla_pkg::SDLA_MAX_AGENTS; i++)
            if (slot_used[i])
                n++;
        return n;
    endfunction

    // Works out the reply to one accepted command and updates the segment.
    function void note_command(logic [2:0] op, logic [7:0] id, logic req);
        int hit;
        int free_slot;
        int slot;
        int count;
        bit sole;
        bit grant;
        logic [1:0] want;
        arbiter_reply_t r;
        hit = -1;
        free_slot = -1;
        count = 0;
        for (int i = 0; i < sdla_pkg::SDLA_MAX_AGENTS; i++)
        begin
            if (slot_used[i])
            begin
                count++;
                if (slot_id[i] == id && hit < 0)
                    hit = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        sole = (count == 1) && (hit >= 0);
        want = {1'b0, req};
        r.status = sdla_pkg::ST_REFUSED;
        case (op)
            sdla_pkg::OP_APPLY:
            begin
                if (single_entry)
                    grant = !seg_lock && (count == 0 || sole);
                else
                    grant = (seg_dir == sdla_pkg::DIR_FREE) ||
                            (seg_dir == want && !seg_lock) || (!seg_lock && sole);
                if (grant)
                begin
                    if (hit < 0 && free_slot < 0)
                        r.status = sdla_pkg::ST_FULL;
                    else
                    begin
                        slot = (hit >= 0) ? hit : free_slot;
                        slot_id[slot] = id;
                        slot_used[slot] = 1'b1;
                        seg_dir = want;
                        if (single_entry)
                            seg_lock = 1'b1;
                        r.status = sdla_pkg::ST_OK;
                    end
                end
            end
            sdla_pkg::OP_RELEASE:
            begin
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b0;
                    r.status = sdla_pkg::ST_OK;
                end
            end
            sdla_pkg::OP_RESET_DIR:
            begin
                if (count == 0)
                begin
                    seg_dir = sdla_pkg::DIR_FREE;
                    r.status = sdla_pkg::ST_OK;
                end
            end
            sdla_pkg::OP_SET_DIR:
            begin
                if (seg_dir == sdla_pkg::DIR_FREE || (sole && seg_dir != want))
                begin
                    seg_dir = want;
                    r.status = sdla_pkg::ST_OK;
                end
            end
            sdla_pkg::OP_TAKE_LOCK:
            begin
                if (!seg_lock)
                begin
                    seg_lock = 1'b1;
                    r.status = sdla_pkg::ST_OK;
                end
            end
            sdla_pkg::OP_DROP_LOCK:
            begin
                if (seg_lock)
                begin
                    seg_lock = 1'b0;
                    r.status = sdla_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        r.direction = seg_dir;
        r.locked = seg_lock;
        r.occupants = 4'(occupant_total());
        commands++;
        if (r.status == sdla_pkg::ST_OK && op == sdla_pkg::OP_APPLY)
            grants++;
        if (r.status == sdla_pkg::ST_FULL)
            full_replies++;
        if (r.status == sdla_pkg::ST_REFUSED)
            refusals++;
        awaited_replies.insert(awaited_replies.size(), r);
    endfunction

    // Compares one reply from the block with the oldest prediction.
    function void check_reply(logic [1:0] st, logic [1:0] dr, logic lk, logic [3:0] cnt);
        arbiter_reply_t r;
        if (awaited_replies.size() == 0)
        begin
            $error("reply with no command outstanding: status %0d", st);
            mismatches++;
            return;
        end
        r = awaited_replies.pop_front();
        if (st !== r.status)
        begin
            $error("status: expected %0d, got %0d", r.status, st);
            mismatches++;
        end
        if (dr !== r.direction)
        begin
            $error("direction_now: expected %b, got %b", r.direction, dr);
            mismatches++;
        end
        if (lk !== r.locked)
        begin
            $error("locked: expected %0d, got %0d", r.locked, lk);
            mismatches++;
        end
        if (cnt !== r.occupants)
        begin
            $error("occupant_count: expected %0d, got %0d", r.occupants, cnt);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    import sdla_pkg::*;

    // The two opcodes the block does not define; both must be refused.
    localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
    localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

    // Cycles without any transfer before the run is declared hung. A correct
    // run never goes more than the longest sender gap plus one command slot
    // without a transfer.
    localparam int STALL_LIMIT = 2000;
    // Long enough for the block to answer a command taken just before.
    localparam int DRAIN_CYCLES = SDLA_MAX_AGENTS + 4;
    localparam int PHASE_ITEMS = 240;
    localparam int POOL_SIZE = 12;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic start;
    logic busy;
    logic [2:0] opcode;
    logic [7:0] agent_id;
    logic requested_direction;
    logic done;
    logic [1:0] status;
    logic signed [1:0] direction_now;
    logic locked;
    logic [3:0] occupant_count;

    segment_arbiter_scoreboard sb = new();

    // While set, the command side never pauses between transfers.
    bit steady;
    int quiet_cycles;
    int mode_writes;
    logic [7:0] id_pool [POOL_SIZE];

    segment_direction_lock_arbiter_unit uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .start               (start),
        .busy                (busy),
        .opcode              (opcode),
        .agent_id            (agent_id),
        .requested_direction (requested_direction),
        .done                (done),
        .status              (status),
        .direction_now       (direction_now),
        .locked              (locked),
        .occupant_count      (occupant_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Monitor: every rising edge it checks a reply strobe, records a command
    // transfer, and runs the watchdog. A reply can never belong to a command
    // taken at the same edge, so the check goes first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (done)
            begin
                sb.check_reply(status, direction_now, locked, occupant_count);
                quiet_cycles = 0;
            end
            if (start && !busy)
            begin
                sb.note_command(opcode, agent_id, requested_direction);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Writes the entry-mode register. It is only called with nothing in
    // flight, so the predictor can switch at the same edge as the block.
    task automatic write_entry_mode(input logic mode);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        sb.set_mode(mode);
        mode_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Presents one command and holds it until the block takes it. Entered and
    // left at a falling edge; start is left high so that back-to-back commands
    // need no extra assignment in between.
    task automatic send_command(input logic [2:0] op, input logic [7:0] id, input logic dir);
        int gap;
        gap = 0;
        if (!steady)
        begin
            // Mostly short pauses, sometimes one long enough to land anywhere
            // in the block's scan of the occupant set.
            if ($urandom_range(0, 99) < 10)
                gap = $urandom_range(1, 15);
            else
                while ($urandom_range(0, 99) < 32)
                    gap++;
        end
        repeat (gap)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        agent_id <= id;
        requested_direction <= dir;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Lowers start and waits until every reply has come back.
    task automatic drain_replies();
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Picks an opcode. Grant-heavy phases fill the occupant set; the others
    // lean on releases and lock handling so single-entry mode keeps moving.
    function automatic logic [2:0] pick_opcode(bit fill_heavy);
        int roll;
        roll = $urandom_range(0, 99);
        if (fill_heavy)
        begin
            if (roll < 48) return OP_APPLY;
            if (roll < 62) return OP_RELEASE;
            if (roll < 70) return OP_SET_DIR;
            if (roll < 78) return OP_RESET_DIR;
            if (roll < 85) return OP_TAKE_LOCK;
            if (roll < 94) return OP_DROP_LOCK;
        end
        else
        begin
            if (roll < 32) return OP_APPLY;
            if (roll < 52) return OP_RELEASE;
            if (roll < 62) return OP_SET_DIR;
            if (roll < 71) return OP_RESET_DIR;
            if (roll < 79) return OP_TAKE_LOCK;
            if (roll < 94) return OP_DROP_LOCK;
        end
        return roll[0] ? OP_SPARE_HIGH : OP_SPARE_LOW;
    endfunction

    // Most agents come from a small pool so that releases and repeat
    // applications find them present; the rest span the whole ID range.
    function automatic logic [7:0] pick_agent();
        if ($urandom_range(0, 99) < 15)
            return 8'($urandom_range(0, 255));
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        start = 1'b0;
        opcode = OP_APPLY;
        agent_id = '0;
        requested_direction = 1'b0;
        steady = 1'b0;
        quiet_cycles = 0;
        mode_writes = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, double-entry mode. The first command finds the
        // direction free.
        write_entry_mode(1'b0);
        send_command(OP_APPLY, 8'd0, 1'b0);
        // Sole occupant applies again for the other direction: granted,
        // and no second entry is made.
        send_command(OP_APPLY, 8'd0, 1'b1);
        // The sole occupant may turn the segment, but not to where it points.
        send_command(OP_SET_DIR, 8'd0, 1'b0);
        send_command(OP_SET_DIR, 8'd0, 1'b0);
        // Clearing the direction is refused while anyone is on the segment.
        send_command(OP_RESET_DIR, 8'd0, 1'b0);
        // Fill the set with agents travelling the same way.
        send_command(OP_APPLY, 8'd255, 1'b0);
        for (int i = 1; i <= 6; i++)
            send_command(OP_APPLY, 8'(i), 1'b0);
        // A newcomer that would be granted finds the set full.
        send_command(OP_APPLY, 8'd200, 1'b0);
        // Opposite direction with several occupants is refused.
        send_command(OP_APPLY, 8'd255, 1'b1);
        send_command(OP_TAKE_LOCK, 8'd0, 1'b0);
        send_command(OP_TAKE_LOCK, 8'd0, 1'b0);
        // Matching direction does not get past the lock.
        send_command(OP_APPLY, 8'd1, 1'b0);
        send_command(OP_DROP_LOCK, 8'd0, 1'b0);
        send_command(OP_DROP_LOCK, 8'd0, 1'b0);
        send_command(OP_RELEASE, 8'd77, 1'b1);
        send_command(OP_RELEASE, 8'd255, 1'b0);
        send_command(OP_SPARE_LOW, 8'd0, 1'b1);
        send_command(OP_SPARE_HIGH, 8'd255, 1'b0);
        drain_replies();

        // Random part: alternate the entry mode, each phase with a fresh
        // agent pool. The third phase runs with no pauses at all.
        for (int phase = 0; phase < 6; phase++)
        begin
            write_entry_mode(phase % 2 == 0);
            id_pool[0] = 8'd0;
            id_pool[1] = 8'd255;
            for (int k = 2; k < POOL_SIZE; k++)
                id_pool[k] = 8'($urandom_range(0, 255));
            steady = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_command(pick_opcode(phase == 1 || phase == 3), pick_agent(),
                             1'($urandom_range(0, 1)));
            drain_replies();
        end
        steady = 1'b0;

        // Let any stray reply show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d commands over %0d mode settings: %0d grants, %0d full, %0d refused.",
                 sb.commands, mode_writes, sb.grants, sb.full_replies, sb.refusals);
        $display("Replies left unmatched: %0d; field mismatches: %0d.",
                 sb.outstanding(), sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### segment_direction_lock_arbiter_unit.f
+incdir+src
src/sdla_pkg.sv
src/segment_direction_lock_arbiter_unit.sv
src/sdla_checker.sv
tb/sv/testbench.sv
